// ===== hw/rtl/sst_pkg.sv =====
// shared types and codes for the scoped symbol table
package sst_pkg;

   localparam int CMD_BITS        = 2;
   localparam int KEY_FIELD_BITS  = 32;
   localparam int LINE_FIELD_BITS = 20;
   localparam int STATUS_BITS     = 2;

   localparam logic [CMD_BITS-1:0] CMD_ENTER   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_EXIT    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DECLARE = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_FIND    = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_REFUSED   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_CAPACITY  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]        command;
      logic [KEY_FIELD_BITS-1:0]  symbol_key;
      logic [LINE_FIELD_BITS-1:0] line_number;
   } sst_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]     status;
      logic [LINE_FIELD_BITS-1:0] found_line;
   } sst_rsp_type;

   typedef struct packed {
      logic load;
      logic check;
      logic scan;
      logic rsp_load;
   } sst_ctrl_type;

   typedef struct packed {
      logic quick;
      logic scan_stop;
   } sst_stat_type;

endpackage

// ===== hw/rtl/sst_ram.sv =====
// generic single write port, single read port ram with registered read
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sst_ctrl.sv =====
// controller state machine for the scoped symbol table
module sst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sst_pkg::sst_ctrl_type ctrl,
   input  sst_pkg::sst_stat_type stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            ctrl.check = 1'b1;
            state_in   = stat.quick ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.scan_stop) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CHECK))
      else $error("accepted request did not start a check");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside done");

   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("done with free slot did not deliver");
`endif

endmodule

// ===== hw/rtl/sst_datapath.sv =====
// binding stack, scope and count registers, scan compare and result registers
module sst_datapath #(
   parameter int TABLE_ENTRIES   = 256,
   parameter int KEY_BITS        = 32,
   parameter int LINE_BITS       = 20,
   parameter int MAX_SCOPE_DEPTH = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sst_pkg::sst_ctrl_type ctrl,
   output sst_pkg::sst_stat_type stat,
   input  sst_pkg::sst_req_type  req_data,
   output sst_pkg::sst_rsp_type  rsp_data
);

   localparam int KFB = sst_pkg::KEY_FIELD_BITS;
   localparam int LFB = sst_pkg::LINE_FIELD_BITS;
   localparam int KW  = (KEY_BITS < KFB) ? KEY_BITS : KFB;
   localparam int LW  = (LINE_BITS < LFB) ? LINE_BITS : LFB;
   localparam int DW  = $clog2(MAX_SCOPE_DEPTH + 1);
   localparam int CW  = $clog2(TABLE_ENTRIES + 1);
   localparam int IW  = $clog2(TABLE_ENTRIES);
   localparam int EW  = KW + LW + DW;

   logic [sst_pkg::CMD_BITS-1:0] cmd_ff, cmd_in;
   logic [KW-1:0]                key_ff, key_in;
   logic [LW-1:0]                line_ff, line_in;
   logic [DW-1:0]                depth_ff, depth_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                ptr_ff, ptr_in;
   logic                         probe_ff, probe_in;
   logic [IW-1:0]                idx_ff, idx_in;
   sst_pkg::sst_rsp_type         res_ff, res_in;
   sst_pkg::sst_rsp_type         rsp_ff, rsp_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   logic [KW-1:0] rd_key;
   logic [LW-1:0] rd_line;
   logic [DW-1:0] rd_scope;

   logic full;
   logic at_max;
   logic key_zero;
   logic scope_hit;
   logic key_hit;
   logic quick;
   logic [sst_pkg::STATUS_BITS-1:0] quick_status;
   logic hit;
   logic ran_out;
   logic scan_stop;
   logic issue;

   sst_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key   = rd_data[EW-1 -: KW];
   assign rd_line  = rd_data[DW +: LW];
   assign rd_scope = rd_data[DW-1:0];

   assign full      = (count_ff == CW'(TABLE_ENTRIES));
   assign at_max    = (depth_ff >= DW'(MAX_SCOPE_DEPTH));
   assign key_zero  = (key_ff == '0);
   assign scope_hit = (rd_scope == depth_ff);
   assign key_hit   = (rd_key == key_ff);

   always_comb begin
      case (cmd_ff)
         sst_pkg::CMD_ENTER: begin
            quick        = 1'b1;
            quick_status = at_max ? sst_pkg::ST_CAPACITY : sst_pkg::ST_OK;
            hit          = 1'b0;
         end
         sst_pkg::CMD_EXIT: begin
            quick        = (depth_ff == '0);
            quick_status = sst_pkg::ST_REFUSED;
            hit          = probe_ff && !scope_hit;
         end
         sst_pkg::CMD_DECLARE: begin
            quick        = key_zero;
            quick_status = sst_pkg::ST_REFUSED;
            hit          = probe_ff && (!scope_hit || key_hit);
         end
         sst_pkg::CMD_FIND: begin
            quick        = key_zero;
            quick_status = sst_pkg::ST_NOT_FOUND;
            hit          = probe_ff && key_hit;
         end
         default: begin
            quick        = 1'b1;
            quick_status = sst_pkg::ST_OK;
            hit          = 1'b0;
         end
      endcase
   end

   assign ran_out   = !probe_ff && (ptr_ff == '0);
   assign scan_stop = hit || ran_out;
   assign issue     = ctrl.scan && !scan_stop && (ptr_ff != '0);
   assign rd_addr   = IW'(ptr_ff - CW'(1));

   assign stat.quick     = quick;
   assign stat.scan_stop = scan_stop;

   assign wr_addr = count_ff[IW-1:0];
   assign wr_data = {key_ff, line_ff, depth_ff};

   always_comb begin
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      line_in  = line_ff;
      depth_in = depth_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      probe_in = issue;
      idx_in   = idx_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;

      if (ctrl.load) begin
         cmd_in  = req_data.command;
         key_in  = req_data.symbol_key[KW-1:0];
         line_in = req_data.line_number[LW-1:0];
         ptr_in  = count_ff;
      end

      if (issue) begin
         ptr_in = ptr_ff - CW'(1);
         idx_in = rd_addr;
      end

      if (ctrl.check && quick) begin
         res_in.status     = quick_status;
         res_in.found_line = '0;
         if (cmd_ff == sst_pkg::CMD_ENTER && !at_max) begin
            depth_in = depth_ff + DW'(1);
         end
      end

      if (ctrl.scan) begin
         if (!scan_stop) begin
            // pop a binding of the closing scope
            if (cmd_ff == sst_pkg::CMD_EXIT && probe_ff && scope_hit) begin
               count_in = CW'(idx_ff);
            end
         end else begin
            res_in.found_line = '0;
            case (cmd_ff)
               sst_pkg::CMD_EXIT: begin
                  depth_in      = depth_ff - DW'(1);
                  res_in.status = sst_pkg::ST_OK;
               end
               sst_pkg::CMD_DECLARE: begin
                  if (probe_ff && scope_hit && key_hit) begin
                     res_in.status = sst_pkg::ST_REFUSED;
                  end else if (full) begin
                     res_in.status = sst_pkg::ST_CAPACITY;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CW'(1);
                     res_in.status = sst_pkg::ST_OK;
                  end
               end
               sst_pkg::CMD_FIND: begin
                  if (probe_ff && key_hit) begin
                     res_in.status     = sst_pkg::ST_OK;
                     res_in.found_line = LFB'(rd_line);
                  end else begin
                     res_in.status = sst_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  res_in.status = sst_pkg::ST_OK;
               end
            endcase
         end
      end

      if (ctrl.rsp_load) begin
         rsp_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         probe_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      line_ff <= line_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("scan pointer above binding count");

   a_probe_live: assert property (@(posedge clock) disable iff (reset)
      probe_ff |-> (CW'(idx_ff) < count_ff))
      else $error("probe of a dead binding");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!full && ctrl.scan && cmd_ff == sst_pkg::CMD_DECLARE))
      else $error("table write without room or outside declare");
`endif

endmodule

// ===== hw/rtl/scoped_symbol_table.sv =====
// scoped symbol table top level: controller, datapath and binding stack
// answered without a stack walk: enter, exit at global scope, and declare or find with key 0;
// others read bindings from the top of the stack down until one stops the walk or the
// bottom binding is passed, and then answer
// throughput: one request at a time, the next accepted the cycle after the result register
// loads; the stack walk and rsp_stall set the rate; reset: synchronous, empties stack, global scope
module scoped_symbol_table #(
   parameter int TABLE_ENTRIES   = 256,
   parameter int KEY_BITS        = 32,
   parameter int LINE_BITS       = 20,
   parameter int MAX_SCOPE_DEPTH = 255
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sst_pkg::sst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sst_pkg::sst_rsp_type rsp_data
);

   sst_pkg::sst_ctrl_type ctrl;
   sst_pkg::sst_stat_type stat;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   sst_datapath #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .KEY_BITS        (KEY_BITS),
      .LINE_BITS       (LINE_BITS),
      .MAX_SCOPE_DEPTH (MAX_SCOPE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== dv/tb.sv =====
// testbench for the scoped symbol table: queued stimulus, scoreboard against a behavioral table
module tb;

   localparam int TABLE_DEPTH = 256;
   localparam int SCOPE_LIMIT = 255;
   localparam int QUIET_TAIL  = 200;
   localparam int ITEM_TARGET = 1300;
   localparam int FILL_BASE   = 32'h9E37_0001;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   sst_pkg::sst_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   sst_pkg::sst_rsp_type rsp_data;

   scoped_symbol_table #(
      .TABLE_ENTRIES  (TABLE_DEPTH),
      .KEY_BITS       (32),
      .LINE_BITS      (20),
      .MAX_SCOPE_DEPTH(SCOPE_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   sst_pkg::sst_req_type pending[$];
   sst_pkg::sst_rsp_type answers_due[$];
   int                   drain_marks[$];
   logic [31:0]          key_pool[16];

   logic [31:0] bind_key[TABLE_DEPTH];
   logic [19:0] bind_line[TABLE_DEPTH];
   int          bind_scope[TABLE_DEPTH];
   int          bind_count;
   int          scope_level;

   int                   mismatches;
   int                   sent_count;
   int                   send_gap;
   int                   stall_left;
   logic                 req_fire;
   sst_pkg::sst_rsp_type due;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // behavioral table: one answer per request, state updated in place
   function automatic sst_pkg::sst_rsp_type table_answer(sst_pkg::sst_req_type rq);
      sst_pkg::sst_rsp_type ans;
      int                   i;
      bit                   dup;
      bit                   hit;
      ans.status     = sst_pkg::ST_OK;
      ans.found_line = '0;
      case (rq.command)
         sst_pkg::CMD_ENTER: begin
            if (scope_level >= SCOPE_LIMIT) ans.status = sst_pkg::ST_CAPACITY;
            else scope_level++;
         end
         sst_pkg::CMD_EXIT: begin
            if (scope_level == 0) begin
               ans.status = sst_pkg::ST_REFUSED;
            end else begin
               while (bind_count > 0 && bind_scope[bind_count-1] == scope_level)
                  bind_count--;
               scope_level--;
            end
         end
         sst_pkg::CMD_DECLARE: begin
            dup = 1'b0;
            for (i = bind_count - 1; i >= 0 && bind_scope[i] == scope_level; i--)
               if (bind_key[i] == rq.symbol_key) dup = 1'b1;
            if (rq.symbol_key == '0 || dup) begin
               ans.status = sst_pkg::ST_REFUSED;
            end else if (bind_count >= TABLE_DEPTH) begin
               ans.status = sst_pkg::ST_CAPACITY;
            end else begin
               bind_key[bind_count]   = rq.symbol_key;
               bind_line[bind_count]  = rq.line_number;
               bind_scope[bind_count] = scope_level;
               bind_count++;
            end
         end
         default: begin
            ans.status = sst_pkg::ST_NOT_FOUND;
            hit = 1'b0;
            if (rq.symbol_key != '0) begin
               for (i = bind_count - 1; i >= 0 && !hit; i--) begin
                  if (bind_key[i] == rq.symbol_key) begin
                     hit            = 1'b1;
                     ans.status     = sst_pkg::ST_OK;
                     ans.found_line = bind_line[i];
                  end
               end
            end
         end
      endcase
      return ans;
   endfunction

   function automatic logic [19:0] rand_line();
      return 20'($urandom_range(0, 20'hFFFFF));
   endfunction

   function automatic logic [31:0] pool_key();
      return key_pool[$urandom_range(0, 15)];
   endfunction

   task automatic add_req(logic [1:0] cmd, logic [31:0] key, logic [19:0] line);
      sst_pkg::sst_req_type r;
      r.command     = cmd;
      r.symbol_key  = key;
      r.line_number = line;
      pending.insert(pending.size(), r);
   endtask

   task automatic scope_block(int nest);
      int n;
      int k;
      add_req(sst_pkg::CMD_ENTER, $urandom(), rand_line());
      n = $urandom_range(1, 7);
      repeat (n) begin
         k = $urandom_range(0, 9);
         if (k < 5) add_req(sst_pkg::CMD_DECLARE, pool_key(), rand_line());
         else if (k < 9) add_req(sst_pkg::CMD_FIND, pool_key(), rand_line());
         else if (nest > 0) scope_block(nest - 1);
         else add_req(sst_pkg::CMD_FIND, $urandom(), rand_line());
      end
      add_req(sst_pkg::CMD_EXIT, $urandom(), rand_line());
   endtask

   task automatic table_fill();
      int i;
      add_req(sst_pkg::CMD_ENTER, $urandom(), rand_line());
      for (i = 0; i < TABLE_DEPTH + 14; i++) begin
         add_req(sst_pkg::CMD_DECLARE, FILL_BASE + i, rand_line());
         if (i % 40 == 0)
            add_req(sst_pkg::CMD_FIND, FILL_BASE + $urandom_range(0, i), rand_line());
      end
      // duplicate in a full table is refused before capacity
      add_req(sst_pkg::CMD_DECLARE, FILL_BASE, rand_line());
      add_req(sst_pkg::CMD_FIND, FILL_BASE + TABLE_DEPTH + 13, rand_line());
      add_req(sst_pkg::CMD_FIND, pool_key(), rand_line());
      add_req(sst_pkg::CMD_EXIT, $urandom(), rand_line());
   endtask

   task automatic deep_dive();
      repeat (SCOPE_LIMIT + 3) add_req(sst_pkg::CMD_ENTER, $urandom(), rand_line());
      add_req(sst_pkg::CMD_DECLARE, pool_key(), rand_line());
      add_req(sst_pkg::CMD_DECLARE, $urandom(), rand_line());
      add_req(sst_pkg::CMD_FIND, pool_key(), rand_line());
      repeat (SCOPE_LIMIT + 3) add_req(sst_pkg::CMD_EXIT, $urandom(), rand_line());
   endtask

   task automatic build_stimulus();
      int k;
      int i;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < 16; i++) key_pool[i] = $urandom();

      add_req(sst_pkg::CMD_FIND, 32'hFFFF_FFFF, rand_line());
      add_req(sst_pkg::CMD_EXIT, $urandom(), rand_line());
      add_req(sst_pkg::CMD_DECLARE, 32'h0, rand_line());
      add_req(sst_pkg::CMD_DECLARE, 32'hFFFF_FFFF, 20'hFFFFF);
      add_req(sst_pkg::CMD_DECLARE, 32'h1, 20'h0);
      add_req(sst_pkg::CMD_DECLARE, 32'hFFFF_FFFF, 20'h12345);
      add_req(sst_pkg::CMD_FIND, 32'hFFFF_FFFF, 20'h0);
      add_req(sst_pkg::CMD_FIND, 32'h0, 20'hFFFFF);
      add_req(sst_pkg::CMD_ENTER, 32'h0, 20'h0);
      add_req(sst_pkg::CMD_FIND, 32'h1, rand_line());
      add_req(sst_pkg::CMD_DECLARE, 32'h1, 20'h54321);
      add_req(sst_pkg::CMD_FIND, 32'h1, rand_line());
      add_req(sst_pkg::CMD_DECLARE, 32'hFFFF_FFFF, 20'h0AAAA);
      add_req(sst_pkg::CMD_EXIT, 32'hFFFF_FFFF, 20'hFFFFF);
      add_req(sst_pkg::CMD_FIND, 32'h1, rand_line());
      add_req(sst_pkg::CMD_FIND, 32'hFFFF_FFFF, rand_line());
      add_req(sst_pkg::CMD_ENTER, $urandom(), rand_line());
      add_req(sst_pkg::CMD_DECLARE, 32'h5, rand_line());
      add_req(sst_pkg::CMD_EXIT, $urandom(), rand_line());
      add_req(sst_pkg::CMD_FIND, 32'h5, rand_line());
      add_req(sst_pkg::CMD_EXIT, $urandom(), rand_line());

      drain_marks.insert(drain_marks.size(), pending.size());
      table_fill();
      drain_marks.insert(drain_marks.size(), pending.size());
      deep_dive();

      while (pending.size() < ITEM_TARGET) begin
         if (drain_marks.size() == 2 && pending.size() > 1000)
            drain_marks.insert(drain_marks.size(), pending.size());
         k = $urandom_range(0, 19);
         if (k < 12) begin
            scope_block(2);
         end else if (k < 16) begin
            if ($urandom_range(0, 1)) add_req(sst_pkg::CMD_DECLARE, pool_key(), rand_line());
            else add_req(sst_pkg::CMD_FIND, pool_key(), rand_line());
         end else if (k < 18) begin
            add_req(2'($urandom_range(0, 3)), $urandom(), rand_line());
         end else begin
            add_req(2'($urandom_range(0, 3)), pool_key(), rand_line());
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() == 0) begin
            req_valid <= 1'b0;
         end else if (drain_marks.size() > 0 && sent_count == drain_marks[0]
                      && answers_due.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            if (drain_marks.size() > 0 && sent_count == drain_marks[0])
               void'(drain_marks.pop_front());
            req_data  <= pending.pop_front();
            req_valid <= 1'b1;
            sent_count++;
            if (pending.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 14);
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (pending.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               flag_mismatch($sformatf("response %h with none outstanding", rsp_data));
            end else begin
               due = answers_due.pop_front();
               if (rsp_data.status !== due.status)
                  flag_mismatch($sformatf("status %h want %h", rsp_data.status, due.status));
               if (rsp_data.found_line !== due.found_line)
                  flag_mismatch($sformatf("found_line %h want %h",
                                          rsp_data.found_line, due.found_line));
            end
         end
         if (req_valid && !req_stall)
            answers_due.insert(answers_due.size(), table_answer(req_data));
      end
      req_fire <= !reset && req_valid && !req_stall;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      req_fire    = 1'b0;
      mismatches  = 0;
      sent_count  = 0;
      send_gap    = 0;
      stall_left  = 0;
      bind_count  = 0;
      scope_level = 0;
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (pending.size() > 0 || req_valid || answers_due.size() > 0) @(posedge clock);
      repeat (TABLE_DEPTH + 40) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

endmodule
